FILE: src/sorted_ip_allow_list_filter_top_macros.svh
// Assertion macros used by the allow-list filter sequencer (sialf_ctrl).
`ifndef SORTED_IP_ALLOW_LIST_FILTER_TOP_MACROS_SVH
`define SORTED_IP_ALLOW_LIST_FILTER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define SIALF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define SIALF_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);
`else
`define SIALF_ASSERT(lbl, prop, msg)
`define SIALF_NEVER(lbl, cond, msg)
`endif

`endif

FILE: src/sialf_pkg.sv
// Types and constants of the sorted IP allow-list filter.
package sialf_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int IP_W        = 32;
    localparam int CMD_W       = 2;
    localparam int MODE_W      = 2;
    localparam int COUNT_OUT_W = 9;
    localparam int S_TUSER_W   = 8;
    localparam int M_TDATA_W   = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_CHECK  = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOW_ALL    = 2'd0,
        MODE_DENY_ALL     = 2'd1,
        MODE_ALLOW_LISTED = 2'd2
    } mode_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [IP_W-1:0]   wr_data;
        logic [ADDR_W-1:0] rd_addr;
    } ram_req_t;

    typedef struct packed {
        logic [COUNT_OUT_W-1:0] entry_count;
        logic                   status;
        logic                   allowed;
    } result_t;

endpackage

FILE: src/sorted_ip_allow_list_filter_top.sv
// Top level of the sorted IP allow-list filter.
//
// Keeps up to 256 IPv4 addresses in ascending order in one simple dual-port RAM and
// answers check, add, remove and clear commands, one word at a time. s_tready is high
// only while the sequencer is idle; a finished result waits in the output register, so
// the next word can be accepted before it is taken. A clear, or a check in allow-all or
// deny-all mode, goes straight to the done state, which sets m_tvalid once the output
// register is free. Otherwise a lower-bound binary search reads and compares one entry
// per probe, up to ceil(log2(n+1)) probes for n stored entries, then reads the entry at
// the lower bound to test for a hit (not when the search ends past the last entry). An
// add then moves each entry at or above the insert point up by one slot, one entry per
// cycle, and writes the new address; a remove moves each entry above the hit down, one
// per cycle. The worst case is a remove of the lowest entry of a full table, its length
// set by the single RAM write port; s_tready rises again with m_tvalid. access_mode is
// to be written through cfg_wr_en and cfg_wr_data only while idle; this is not enforced.
module sorted_ip_allow_list_filter_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [sialf_pkg::MODE_W-1:0]       cfg_wr_data,   // access_mode
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sialf_pkg::IP_W-1:0]         s_tdata,       // ip_address
    input  logic [sialf_pkg::S_TUSER_W-1:0]    s_tuser,       // cmd, zero pad
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sialf_pkg::M_TDATA_W-1:0]    m_tdata        // allowed, status, entry_count
);
    import sialf_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    ram_req_t          ram_req;
    logic [IP_W-1:0]   ram_rdata;
    result_t           m_result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_ALLOW_ALL;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

    sialf_ram #(
        .WIDTH (IP_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rdata)
    );

    sialf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .in_cmd    (cmd_t'(s_tuser[CMD_W-1:0])),
        .in_addr   (s_tdata),
        .mode      (mode_reg),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_result  (m_result)
    );

    assign m_tdata = M_TDATA_W'(m_result);

endmodule

FILE: src/sialf_ram.sv
// Generic simple dual-port RAM with registered read.
module sialf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/sialf_ctrl.sv
// Sequencer: binary search, shift and result register over one RAM port pair.
`include "sorted_ip_allow_list_filter_top_macros.svh"

module sialf_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  sialf_pkg::cmd_t                in_cmd,
    input  logic [sialf_pkg::IP_W-1:0]     in_addr,
    input  logic [sialf_pkg::MODE_W-1:0]   mode,
    output sialf_pkg::ram_req_t            ram_req,
    input  logic [sialf_pkg::IP_W-1:0]     ram_rdata,
    output logic                           m_valid,
    input  logic                           m_ready,
    output sialf_pkg::result_t             m_result
);
    import sialf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH_RD,
        ST_SEARCH_CMP,
        ST_HIT_CMP,
        ST_SHIFT_UP,
        ST_INSERT,
        ST_SHIFT_DOWN,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [IP_W-1:0]   key_reg, key_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [ADDR_W-1:0] mid_reg, mid_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic              allowed_reg, allowed_next;
    logic              status_reg, status_next;
    logic              m_valid_reg, m_valid_next;
    result_t           m_result_reg, m_result_next;

    logic              resolve;
    logic              hit;
    logic [CNT_W-1:0]  mid_calc;
    logic [CNT_W-1:0]  idx_dec;
    logic [CNT_W-1:0]  idx_dec2;
    logic [CNT_W-1:0]  idx_inc2;
    logic [CNT_W-1:0]  pos_inc;
    logic [CNT_W-1:0]  used_dec;

    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign idx_dec  = idx_reg - CNT_W'(1);
    assign idx_dec2 = idx_reg - CNT_W'(2);
    assign idx_inc2 = idx_reg + CNT_W'(2);
    assign pos_inc  = lo_reg + CNT_W'(1);
    assign used_dec = used_reg - CNT_W'(1);

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        idx_next      = idx_reg;
        used_next     = used_reg;
        allowed_next  = allowed_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_result_next = m_result_reg;
        ram_req       = '0;
        resolve       = 1'b0;
        hit           = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next     = in_cmd;
                    key_next     = in_addr;
                    lo_next      = '0;
                    hi_next      = used_reg;
                    allowed_next = 1'b0;
                    status_next  = 1'b0;
                    case (in_cmd)
                        CMD_CHECK: begin
                            if (mode == MODE_ALLOW_ALL) begin
                                allowed_next = 1'b1;
                                state_next   = ST_DONE;
                            end else if (mode == MODE_ALLOW_LISTED) begin
                                state_next = ST_SEARCH_RD;
                            end else begin
                                state_next = ST_DONE;
                            end
                        end
                        CMD_ADD, CMD_REMOVE: begin
                            state_next = ST_SEARCH_RD;
                        end
                        CMD_CLEAR: begin
                            used_next  = '0;
                            state_next = ST_DONE;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SEARCH_RD: begin
                if (lo_reg < hi_reg) begin
                    mid_next       = mid_calc[ADDR_W-1:0];
                    ram_req.rd_addr = mid_calc[ADDR_W-1:0];
                    state_next     = ST_SEARCH_CMP;
                end else if (lo_reg < used_reg) begin
                    ram_req.rd_addr = lo_reg[ADDR_W-1:0];
                    state_next     = ST_HIT_CMP;
                end else begin
                    resolve = 1'b1;
                end
            end
            ST_SEARCH_CMP: begin
                if (ram_rdata < key_reg) begin
                    lo_next = CNT_W'(mid_reg) + CNT_W'(1);
                end else begin
                    hi_next = CNT_W'(mid_reg);
                end
                state_next = ST_SEARCH_RD;
            end
            ST_HIT_CMP: begin
                resolve = 1'b1;
                hit     = (ram_rdata == key_reg);
            end
            ST_SHIFT_UP: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = idx_reg[ADDR_W-1:0];
                ram_req.wr_data = ram_rdata;
                if (idx_dec > lo_reg) begin
                    ram_req.rd_addr = idx_dec2[ADDR_W-1:0];
                    idx_next        = idx_dec;
                end else begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = lo_reg[ADDR_W-1:0];
                ram_req.wr_data = key_reg;
                used_next       = used_reg + CNT_W'(1);
                state_next      = ST_DONE;
            end
            ST_SHIFT_DOWN: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = idx_reg[ADDR_W-1:0];
                ram_req.wr_data = ram_rdata;
                if (idx_inc2 < used_reg) begin
                    ram_req.rd_addr = idx_inc2[ADDR_W-1:0];
                    idx_next        = idx_reg + CNT_W'(1);
                end else begin
                    used_next  = used_dec;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_result_next.allowed     = allowed_reg;
                    m_result_next.status      = status_reg;
                    m_result_next.entry_count = COUNT_OUT_W'(used_reg);
                    state_next                = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (resolve) begin
            state_next = ST_DONE;
            case (cmd_reg)
                CMD_CHECK: begin
                    allowed_next = hit;
                end
                CMD_ADD: begin
                    if (!hit) begin
                        if (used_reg >= CNT_W'(TABLE_DEPTH)) begin
                            status_next = 1'b1;
                        end else if (used_reg > lo_reg) begin
                            ram_req.rd_addr = used_dec[ADDR_W-1:0];
                            idx_next        = used_reg;
                            state_next      = ST_SHIFT_UP;
                        end else begin
                            state_next = ST_INSERT;
                        end
                    end
                end
                CMD_REMOVE: begin
                    if (hit) begin
                        if (pos_inc < used_reg) begin
                            ram_req.rd_addr = pos_inc[ADDR_W-1:0];
                            idx_next        = lo_reg;
                            state_next      = ST_SHIFT_DOWN;
                        end else begin
                            used_next = used_dec;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        idx_reg      <= idx_next;
        allowed_reg  <= allowed_next;
        status_reg   <= status_next;
        m_result_reg <= m_result_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

    `SIALF_NEVER(a_used_bound, used_reg > CNT_W'(TABLE_DEPTH), "entry count above table depth")
    `SIALF_ASSERT(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready, "ready after accept")
    `SIALF_ASSERT(a_wr_in_range, ram_req.wr_en |-> (CNT_W'(ram_req.wr_addr) <= used_reg), "write past end")
    `SIALF_ASSERT(a_insert_room, (state_reg == ST_INSERT) |-> (used_reg < CNT_W'(TABLE_DEPTH)), "insert into full table")

endmodule
